/* rtl/core/slfp_pkg.sv */
// Shared types, character codes and constants for the scan line field parser.
// No dependencies; every module of the block but slfp_in_stage imports this package.
package slfp_pkg;

  localparam int MAX_LINE_LEN = 256;
  localparam int FRAC_DIGITS = 3;
  localparam int LEN_W = $clog2(MAX_LINE_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINE_LEN);
  localparam logic [1:0] FRAC_KEEP = 2'(FRAC_DIGITS);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_ID_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MAX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT = 3'd4;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_O = 8'h4F;

  localparam logic [18:0] MAG_MAX = '1;
  localparam logic [8:0] ID_SAT = 9'd256;

  typedef enum logic [1:0] {
    STATUS_ACCEPT = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_OVERLONG = 2'd2
  } status_t;

  typedef enum logic [9:0] {
    PH_START      = 10'b0000000001,
    PH_ID_FIRST   = 10'b0000000010,
    PH_ID_MORE    = 10'b0000000100,
    PH_EXPECT_O   = 10'b0000001000,
    PH_SIGN       = 10'b0000010000,
    PH_AFTER_SIGN = 10'b0000100000,
    PH_INT        = 10'b0001000000,
    PH_POINT      = 10'b0010000000,
    PH_FRAC       = 10'b0100000000,
    PH_BAD        = 10'b1000000000
  } phase_t;

  typedef struct packed {
    logic [7:0] id_min;
    logic [7:0] id_max;
    logic signed [19:0] offset_min;
    logic signed [19:0] offset_max;
    logic [7:0] slot_limit;
  } cfg_t;

  typedef struct packed {
    status_t status;
    logic [7:0] ident;
    logic signed [19:0] offset_mdeg;
    logic [7:0] line_slot;
  } result_t;

  // Weight in millidegrees of the next fraction digit, given how many are already taken.
  function automatic logic [6:0] frac_weight(input logic [1:0] taken);
    logic [6:0] w;
    unique case (taken)
      2'd0: w = 7'd100;
      2'd1: w = 7'd10;
      2'd2: w = 7'd1;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/slfp_cfg_regs.sv */
// Configuration registers of the scan line field parser: range limits and slot count.
// Depends on slfp_pkg for the register indexes and the cfg_t bundle.
module slfp_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [slfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slfp_pkg::CFG_DATA_W-1:0] cfg_data,
  output slfp_pkg::cfg_t cfg
);
  import slfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.id_min <= 8'd1;
      cfg.id_max <= 8'd16;
      cfg.offset_min <= -20'sd10000;
      cfg.offset_max <= 20'sd10000;
      cfg.slot_limit <= 8'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ID_MIN: cfg.id_min <= cfg_data[7:0];
        REG_ID_MAX: cfg.id_max <= cfg_data[7:0];
        REG_OFFSET_MIN: cfg.offset_min <= $signed(cfg_data);
        REG_OFFSET_MAX: cfg.offset_max <= $signed(cfg_data);
        REG_SLOT_LIMIT: cfg.slot_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/slfp_in_stage.sv */
// Input register of the scan line field parser: holds one received byte for the parse step.
// Depends on nothing beyond the clock and reset.
module slfp_in_stage (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] rx_byte,
  output logic held,
  output logic [7:0] held_byte,
  input  logic take
);

  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

/* rtl/core/slfp_parse.sv */
// Line parser: phase tracking, field accumulation, range check and result register.
// Depends on slfp_pkg for phases, character codes, cfg_t and result_t.
module slfp_parse (
  input  logic clk,
  input  logic rst,
  input  slfp_pkg::cfg_t cfg,
  input  logic held,
  input  logic [7:0] held_byte,
  output logic take,
  output logic out_valid,
  input  logic out_ready,
  output slfp_pkg::result_t result
);
  import slfp_pkg::*;

  phase_t phase, phase_next;
  logic [LEN_W-1:0] line_length, line_length_next;
  logic [8:0] id_accum, id_accum_next;
  logic [18:0] offset_magnitude, offset_magnitude_next;
  logic offset_negative, offset_negative_next;
  logic [1:0] fraction_digits, fraction_digits_next;
  logic [7:0] next_slot, next_slot_next;

  logic is_eol, printable, dig, emit, ok;
  logic [3:0] d;
  logic [11:0] id_sum;
  logic [22:0] int_sum;
  logic [19:0] frac_sum;
  logic [18:0] int_mag, frac_mag;
  logic signed [19:0] off;
  logic [8:0] slot_inc;
  result_t result_next;

  assign is_eol = (held_byte == CHAR_CR) || (held_byte == CHAR_LF);
  assign printable = (held_byte >= CHAR_SPACE) && (held_byte <= CHAR_TILDE);
  assign dig = (held_byte >= CHAR_ZERO) && (held_byte <= CHAR_NINE);
  assign d = held_byte[3:0];

  assign emit = (is_eol && (line_length != '0)) || (printable && (line_length == LEN_LIMIT));
  assign take = held && (!emit || !out_valid || out_ready);

  assign id_sum = 12'(id_accum) * 12'd10 + 12'(d);
  assign int_sum = 23'(offset_magnitude) * 23'd10 + 23'(d) * 23'd1000;
  assign frac_sum = 20'(offset_magnitude) + 20'(d) * 20'(frac_weight(fraction_digits));
  assign int_mag = (int_sum > 23'(MAG_MAX)) ? MAG_MAX : int_sum[18:0];
  assign frac_mag = (frac_sum > 20'(MAG_MAX)) ? MAG_MAX : frac_sum[18:0];

  assign off = offset_negative ? -$signed({1'b0, offset_magnitude})
                               : $signed({1'b0, offset_magnitude});
  assign ok = ((phase == PH_INT) || (phase == PH_FRAC)) &&
              (offset_magnitude != MAG_MAX) &&
              (id_accum >= {1'b0, cfg.id_min}) && (id_accum <= {1'b0, cfg.id_max}) &&
              (off >= cfg.offset_min) && (off <= cfg.offset_max);
  assign slot_inc = {1'b0, next_slot} + 9'd1;

  always_comb begin
    phase_next = phase;
    line_length_next = line_length;
    id_accum_next = id_accum;
    offset_magnitude_next = offset_magnitude;
    offset_negative_next = offset_negative;
    fraction_digits_next = fraction_digits;
    next_slot_next = next_slot;
    result_next.status = STATUS_REJECT;
    result_next.ident = '0;
    result_next.offset_mdeg = '0;
    result_next.line_slot = '0;

    if (is_eol || (printable && line_length == LEN_LIMIT)) begin
      if (emit) begin
        phase_next = PH_START;
        line_length_next = '0;
        id_accum_next = '0;
        offset_magnitude_next = '0;
        offset_negative_next = 1'b0;
        fraction_digits_next = '0;
        if (!is_eol) begin
          result_next.status = STATUS_OVERLONG;
        end else if (ok) begin
          result_next.status = STATUS_ACCEPT;
          result_next.ident = id_accum[7:0];
          result_next.offset_mdeg = off;
          result_next.line_slot = next_slot;
          next_slot_next = (slot_inc > {1'b0, cfg.slot_limit}) ? 8'd1 : slot_inc[7:0];
        end
      end
    end else if (printable) begin
      line_length_next = line_length + LEN_W'(1);
      phase_next = PH_BAD;
      unique case (phase)
        PH_START: begin
          if (held_byte == CHAR_D) phase_next = PH_ID_FIRST;
        end
        PH_ID_FIRST, PH_ID_MORE: begin
          if (dig) begin
            id_accum_next = (id_sum > 12'(ID_SAT)) ? ID_SAT : id_sum[8:0];
            phase_next = PH_ID_MORE;
          end else if (held_byte == CHAR_COMMA && phase == PH_ID_MORE) begin
            phase_next = PH_EXPECT_O;
          end
        end
        PH_EXPECT_O: begin
          if (held_byte == CHAR_O) phase_next = PH_SIGN;
        end
        PH_SIGN, PH_AFTER_SIGN: begin
          if (phase == PH_SIGN && (held_byte == CHAR_PLUS || held_byte == CHAR_MINUS)) begin
            offset_negative_next = (held_byte == CHAR_MINUS);
            phase_next = PH_AFTER_SIGN;
          end else if (dig) begin
            offset_magnitude_next = int_mag;
            phase_next = PH_INT;
          end else if (held_byte == CHAR_POINT) begin
            phase_next = PH_POINT;
          end
        end
        PH_INT: begin
          if (dig) begin
            offset_magnitude_next = int_mag;
            phase_next = PH_INT;
          end else if (held_byte == CHAR_POINT) begin
            phase_next = PH_POINT;
          end
        end
        PH_POINT, PH_FRAC: begin
          if (dig) begin
            if (fraction_digits < FRAC_KEEP) begin
              fraction_digits_next = fraction_digits + 2'd1;
              offset_magnitude_next = frac_mag;
            end
            phase_next = PH_FRAC;
          end
        end
        default: phase_next = PH_BAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      line_length <= '0;
      id_accum <= '0;
      offset_magnitude <= '0;
      offset_negative <= 1'b0;
      fraction_digits <= '0;
      next_slot <= 8'd1;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        line_length <= line_length_next;
        id_accum <= id_accum_next;
        offset_magnitude <= offset_magnitude_next;
        offset_negative <= offset_negative_next;
        fraction_digits <= fraction_digits_next;
        next_slot <= next_slot_next;
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result <= result_next;
    end
  end

endmodule

/* rtl/core/scan_line_field_parser.sv */
// Scan line field parser: one received byte per request; a result for every non-empty line.
// A line's last byte is held in the input register, its result then in the result register.
// Throughput: one byte per cycle; a line end stalls while the last result awaits out_ready.
// Reset: limits take their default values, the slot returns to one, parsing restarts.
// Depends on slfp_pkg, slfp_cfg_regs, slfp_in_stage and slfp_parse.
module scan_line_field_parser (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [slfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] rx_byte,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic [7:0] ident,
  output logic signed [19:0] offset_mdeg,
  output logic [7:0] line_slot
);
  import slfp_pkg::*;

  cfg_t cfg;
  result_t result;
  logic held, take;
  logic [7:0] held_byte;

  slfp_cfg_regs u_cfg (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  slfp_in_stage u_in (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .held(held), .held_byte(held_byte), .take(take)
  );

  slfp_parse u_parse (
    .clk(clk), .rst(rst), .cfg(cfg), .held(held), .held_byte(held_byte), .take(take),
    .out_valid(out_valid), .out_ready(out_ready), .result(result)
  );

  assign status = result.status;
  assign ident = result.ident;
  assign offset_mdeg = result.offset_mdeg;
  assign line_slot = result.line_slot;

`ifndef NO_ASSERTIONS
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STATUS_ACCEPT || status == STATUS_REJECT ||
                   status == STATUS_OVERLONG))
    else $error("result status outside the defined codes");

  a_accept_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_ACCEPT) |-> (line_slot != 8'd0))
    else $error("accepted line carries slot zero");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STATUS_ACCEPT) |->
      (ident == 8'd0 && offset_mdeg == 20'sd0 && line_slot == 8'd0))
    else $error("rejected or dropped line carries field data");

  a_take_needs_byte: assert property (@(posedge clk) disable iff (rst)
    take |-> held)
    else $error("parse step consumed an empty input register");
`endif

endmodule

/* test/scan_line_field_parser_check.sv */
`timescale 1ns / 1ps
// Checker for the scan line field parser: it follows register writes and accepted bytes,
// predicts the result of every line, and compares each accepted result with the oldest one.
// Depends on slfp_pkg for the character codes, register indexes, phases and result type.
module scan_line_field_parser_check (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [slfp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  input  logic in_ready,
  input  logic [7:0] rx_byte,
  input  logic out_valid,
  input  logic out_ready,
  input  logic [1:0] status,
  input  logic [7:0] ident,
  input  logic signed [19:0] offset_mdeg,
  input  logic [7:0] line_slot,
  output int failures,
  output int outstanding
);
  import slfp_pkg::*;

  logic [7:0] id_lo;
  logic [7:0] id_hi;
  logic [7:0] slot_cap;
  logic signed [19:0] off_lo;
  logic signed [19:0] off_hi;

  phase_t phase;
  int unsigned line_len;
  int unsigned id_acc;
  int unsigned mag;
  int unsigned frac_taken;
  int unsigned slot_next;
  logic neg;

  result_t expected_lines[$];

  task automatic report_mismatch(input string msg);
    if (failures < 100) begin
      $display("%0t ns: %s", $time, msg);
    end
    failures++;
  endtask

  function automatic void queue_result(input result_t r);
    expected_lines.insert(expected_lines.size(), r);
  endfunction

  function automatic void restart_line();
    phase = PH_START;
    line_len = 0;
    id_acc = 0;
    mag = 0;
    neg = 1'b0;
    frac_taken = 0;
  endfunction

  function automatic void set_mag(input int unsigned v);
    mag = (v > MAG_MAX) ? MAG_MAX : v;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic is_digit;
    int unsigned d;
    int unsigned weight;
    phase_t nxt;
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d = c - CHAR_ZERO;
    nxt = PH_BAD;
    case (phase)
      PH_START: begin
        if (c == CHAR_D) nxt = PH_ID_FIRST;
      end
      PH_ID_FIRST, PH_ID_MORE: begin
        if (is_digit) begin
          id_acc = (id_acc * 10 + d > ID_SAT) ? ID_SAT : id_acc * 10 + d;
          nxt = PH_ID_MORE;
        end else if (c == CHAR_COMMA && phase == PH_ID_MORE) begin
          nxt = PH_EXPECT_O;
        end
      end
      PH_EXPECT_O: begin
        if (c == CHAR_O) nxt = PH_SIGN;
      end
      PH_SIGN, PH_AFTER_SIGN: begin
        if (phase == PH_SIGN && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
          neg = (c == CHAR_MINUS);
          nxt = PH_AFTER_SIGN;
        end else if (is_digit) begin
          set_mag(mag * 10 + d * 1000);
          nxt = PH_INT;
        end else if (c == CHAR_POINT) begin
          nxt = PH_POINT;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          set_mag(mag * 10 + d * 1000);
          nxt = PH_INT;
        end else if (c == CHAR_POINT) begin
          nxt = PH_POINT;
        end
      end
      PH_POINT, PH_FRAC: begin
        if (is_digit) begin
          // Fraction digits past the kept ones are dropped, which truncates toward zero.
          if (frac_taken < FRAC_DIGITS) begin
            frac_taken++;
            case (frac_taken)
              1: weight = 100;
              2: weight = 10;
              default: weight = 1;
            endcase
            set_mag(mag + d * weight);
          end
          nxt = PH_FRAC;
        end
      end
      default: begin
      end
    endcase
    phase = nxt;
  endfunction

  function automatic void finish_line();
    int off;
    logic ok;
    result_t r;
    off = neg ? -int'(mag) : int'(mag);
    ok = (phase == PH_INT || phase == PH_FRAC) && mag != MAG_MAX &&
         id_acc >= id_lo && id_acc <= id_hi && off >= off_lo && off <= off_hi;
    r = '0;
    if (ok) begin
      r.status = STATUS_ACCEPT;
      r.ident = id_acc[7:0];
      r.offset_mdeg = off[19:0];
      r.line_slot = slot_next[7:0];
      slot_next++;
      if (slot_next > slot_cap) slot_next = 1;
    end else begin
      r.status = STATUS_REJECT;
    end
    queue_result(r);
    restart_line();
  endfunction

  function automatic void take_byte(input logic [7:0] c);
    result_t r;
    if (c == CHAR_CR || c == CHAR_LF) begin
      if (line_len != 0) finish_line();
    end else if (c >= CHAR_SPACE && c <= CHAR_TILDE) begin
      line_len++;
      if (line_len > MAX_LINE_LEN) begin
        restart_line();
        r = '0;
        r.status = STATUS_OVERLONG;
        queue_result(r);
      end else begin
        parse_char(c);
      end
    end
  endfunction

  function automatic void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ID_MIN: id_lo = data[7:0];
      REG_ID_MAX: id_hi = data[7:0];
      REG_OFFSET_MIN: off_lo = data;
      REG_OFFSET_MAX: off_hi = data;
      REG_SLOT_LIMIT: slot_cap = data[7:0];
      default: begin
      end
    endcase
  endfunction

  task automatic check_result();
    result_t want;
    if (expected_lines.size() == 0) begin
      report_mismatch($sformatf("result with no line pending: status %0d ident %0d %s",
                                status, ident,
                                $sformatf("offset %0d slot %0d", offset_mdeg, line_slot)));
    end else begin
      want = expected_lines.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (ident !== want.ident)
        report_mismatch($sformatf("ident %0d, expected %0d", ident, want.ident));
      if (offset_mdeg !== want.offset_mdeg)
        report_mismatch($sformatf("offset %0d, expected %0d", offset_mdeg, want.offset_mdeg));
      if (line_slot !== want.line_slot)
        report_mismatch($sformatf("slot %0d, expected %0d", line_slot, want.line_slot));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      id_lo = 8'd1;
      id_hi = 8'd16;
      off_lo = -20'sd10000;
      off_hi = 20'sd10000;
      slot_cap = 8'd4;
      slot_next = 1;
      failures = 0;
      restart_line();
      expected_lines.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_write) write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) take_byte(rx_byte);
    end
    outstanding = expected_lines.size();
  end

endmodule

/* test/scan_line_field_parser_test.sv */
`timescale 1ns / 1ps
// Top of the scan line field parser testbench: clock, reset, register writes and byte
// requests, with idle and stall phases. Depends on slfp_pkg, the parser and its checker.
module scan_line_field_parser_test;
  import slfp_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] rx_byte;
  logic out_valid;
  logic out_ready;
  logic [1:0] status;
  logic [7:0] ident;
  logic signed [19:0] offset_mdeg;
  logic [7:0] line_slot;

  int failures;
  int outstanding;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int cur_id_lo;
  int cur_id_hi;
  int cur_off_lo;
  int cur_off_hi;
  logic [7:0] line_bytes[$];

  scan_line_field_parser DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .ident(ident),
    .offset_mdeg(offset_mdeg),
    .line_slot(line_slot)
  );

  scan_line_field_parser_check line_checker (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .ident(ident),
    .offset_mdeg(offset_mdeg),
    .line_slot(line_slot),
    .failures(failures),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver either holds off for a counted stretch or stalls at random.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("scan_line_field_parser verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte = b;
    do @(posedge clk); while (!in_ready);
    if (b == CHAR_CR || b == CHAR_LF || (b >= CHAR_SPACE && b <= CHAR_TILDE)) bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_queued();
    foreach (line_bytes[i]) send_byte(line_bytes[i]);
  endtask

  function automatic void queue_byte(input logic [7:0] b);
    line_bytes.insert(line_bytes.size(), b);
  endfunction

  function automatic void append_text(input string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic logic [7:0] ignored_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CHAR_CR || b == CHAR_LF ||
                                (b >= CHAR_SPACE && b <= CHAR_TILDE));
    return b;
  endfunction

  function automatic string id_text();
    int v;
    case ($urandom_range(3))
      0, 1: v = (cur_id_lo <= cur_id_hi) ? $urandom_range(cur_id_hi, cur_id_lo)
                                         : $urandom_range(255);
      2: v = $urandom_range(300);
      default: v = $urandom_range(99999);
    endcase
    if ($urandom_range(7) == 0) return {"0", $sformatf("%0d", v)};
    return $sformatf("%0d", v);
  endfunction

  function automatic string offset_text();
    int v;
    int m;
    string s;
    string frac;
    case ($urandom_range(4))
      0, 1, 2: begin
        if (cur_off_lo <= cur_off_hi)
          v = cur_off_lo + int'($urandom_range(cur_off_hi - cur_off_lo));
        else
          v = int'($urandom_range(800000)) - 400000;
      end
      3: v = $urandom_range(1) ? int'($urandom_range(999999)) : -int'($urandom_range(999999));
      default: v = int'($urandom_range(99999999));
    endcase
    m = (v < 0) ? -v : v;
    if (v < 0 || (v == 0 && $urandom_range(3) == 0)) s = "-";
    else s = ($urandom_range(3) == 0) ? "+" : "";
    frac = $sformatf("%03d", m % 1000);
    case ($urandom_range(3))
      0: s = {s, $sformatf("%0d", m / 1000)};
      1: s = {s, $sformatf("%0d", m / 1000), ".", frac};
      2: s = {s, (m / 1000 == 0) ? "" : $sformatf("%0d", m / 1000), ".",
              frac.substr(0, $urandom_range(2))};
      default: begin
        s = {s, $sformatf("%0d", m / 1000), ".", frac, $sformatf("%0d", $urandom_range(9))};
        if ($urandom_range(1)) s = {s, $sformatf("%0d", $urandom_range(9))};
      end
    endcase
    return s;
  endfunction

  // Mostly well-formed lines with random fields; some are damaged, some are noise or overlong.
  function automatic void make_random_line();
    int kind;
    int pos;
    line_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 2) begin
      repeat ($urandom_range(MAX_LINE_LEN + 20, MAX_LINE_LEN + 1))
        queue_byte(8'($urandom_range(126, 32)));
    end else if (kind < 10) begin
      repeat ($urandom_range(12, 1)) queue_byte(8'($urandom));
    end else begin
      append_text({"D", id_text(), ",O", offset_text()});
      if (kind < 25) begin
        pos = $urandom_range(line_bytes.size() - 1);
        if ($urandom_range(1)) line_bytes[pos] = 8'($urandom_range(126, 32));
        else line_bytes.delete(pos);
      end
      if ($urandom_range(9) == 0)
        line_bytes.insert($urandom_range(line_bytes.size()), ignored_byte());
    end
    case ($urandom_range(2))
      0: queue_byte(CHAR_CR);
      1: queue_byte(CHAR_LF);
      default: begin
        queue_byte(CHAR_CR);
        queue_byte(CHAR_LF);
      end
    endcase
  endfunction

  task automatic run_lines(input int byte_goal);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < byte_goal) begin
      make_random_line();
      send_queued();
    end
  endtask

  task automatic drain_lines();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int id_lo, input int id_hi, input int off_lo,
                               input int off_hi, input int slot);
    cur_id_lo = id_lo;
    cur_id_hi = id_hi;
    cur_off_lo = off_lo;
    cur_off_hi = off_hi;
    put_reg(REG_ID_MIN, {12'($urandom), 8'(id_lo)});
    put_reg(REG_ID_MAX, {12'($urandom), 8'(id_hi)});
    put_reg(REG_OFFSET_MIN, 20'(off_lo));
    put_reg(REG_OFFSET_MAX, 20'(off_hi));
    put_reg(REG_SLOT_LIMIT, {12'($urandom), 8'(slot)});
    cfg_write = 1'b0;
  endtask

  task automatic send_known_lines();
    send_text("D1,O0\r");
    send_text("D16,O10\n");
    send_text("D0,O1\n");
    send_text("D17,O-1\n");
    send_text("D5,O-10\n");
    send_text("D5,O-10.001\n");
    send_text("D05,O+9.9999\n");
    send_text("D5,O-0\r\n");
    send_text("D5,O.5\n");
    send_text("D5,O1.\n");
    send_text("D,O1\n");
    send_text("D999,O1\n");
    send_text("D5,O99999999\n");
    send_text("D1,O1.2.3\n");
    send_text("d1,O1\n");
    // Bytes outside the printable range vanish from the line.
    send_byte(CHAR_D);
    send_byte(8'h01);
    send_text("2,O");
    send_byte(8'h9F);
    send_text("3");
    send_byte(8'h7F);
    send_byte(8'hFF);
    send_text("\n");
    send_text("X~ \n");
    send_text("D1,O+-1\n");
    send_text("D1,O1x\n");
    send_text("\n");
    // A line of exactly the maximum length is still parsed; one byte more drops it.
    line_bytes.delete();
    append_text("D1,O");
    repeat (MAX_LINE_LEN - 4) queue_byte(CHAR_ZERO);
    queue_byte(CHAR_LF);
    send_queued();
    line_bytes.delete();
    append_text("D1,O");
    repeat (MAX_LINE_LEN - 3) queue_byte(CHAR_ZERO);
    queue_byte(CHAR_LF);
    send_queued();
    send_text("D2,O1\n");
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    cur_id_lo = 1;
    cur_id_hi = 16;
    cur_off_lo = -10000;
    cur_off_hi = 10000;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    send_known_lines();

    drain_lines();
    apply_setting(0, 255, -360000, 360000, 255);
    send_text("D0,O-360\n");
    send_text("D255,O360.000\n");
    send_text("D255,O360.001\n");
    send_text("D256,O0\n");
    send_text("D0,O-524.287\n");
    send_text("D0,O524.286\r");
    run_lines(50);

    drain_lines();
    send_idle_pct = 62;
    apply_setting(5, 5, 0, 0, 1);
    run_lines(50);

    drain_lines();
    send_idle_pct = 0;
    recv_stall_pct = 62;
    apply_setting(200, 10, 360000, -360000, 3);
    run_lines(50);

    drain_lines();
    send_idle_pct = 10;
    recv_stall_pct = 10;
    cur_id_lo = $urandom_range(40);
    cur_off_lo = -int'($urandom_range(360000));
    apply_setting(cur_id_lo, cur_id_lo + $urandom_range(215), cur_off_lo,
                  int'($urandom_range(360000)), $urandom_range(8, 1));
    run_lines(50);

    // The receiver holds off while bytes keep coming, so the block must stall its input.
    drain_lines();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    apply_setting(1, 16, -10000, 10000, 2);
    hold_left = 400;
    repeat (8) begin
      make_random_line();
      send_queued();
    end

    drain_lines();
    if (failures == 0) begin
      $display("scan_line_field_parser verification clean");
    end else begin
      $display("scan_line_field_parser verification failed");
    end
    $finish;
  end

endmodule
